// ===== sv/mie_pkg.sv =====
// Package for the MIPS64 integer execute core.
// Holds the shared constants, controller state type and command/status structs.
// Used by mie_ctrl, mie_dp and the top level; depends on nothing.
package mie_pkg;

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW = $clog2(REG_COUNT);

  localparam logic [31:0] RESET_VECTOR_DEFAULT = 32'hBFC0_0000;

  // Memory request codes.
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Access size codes.
  localparam logic [1:0] SIZE_BYTE   = 2'd0;
  localparam logic [1:0] SIZE_HALF   = 2'd1;
  localparam logic [1:0] SIZE_WORD   = 2'd2;
  localparam logic [1:0] SIZE_DOUBLE = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RS,
    S_RT,
    S_EXEC,
    S_DIV
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic rd_rt;
    logic latch_a;
    logic latch_b;
    logic exec;
    logic div_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_start;
    logic div_done;
  } status_t;

endpackage

// ===== sv/mie_item_if.sv =====
// Input channel interface of the MIPS64 integer execute core.
// Carries valid, ready and one input item; uses no package.
interface mie_item_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [31:0] instruction;
  logic [63:0] load_value;

  modport source (output valid, item_kind, instruction, load_value, input ready);
  modport sink (input valid, item_kind, instruction, load_value, output ready);
endinterface

// ===== sv/mie_result_if.sv =====
// Result channel interface of the MIPS64 integer execute core.
// Carries valid, ready and one result item; uses no package.
interface mie_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mem_request;
  logic [1:0]  access_size;
  logic [31:0] mem_address;
  logic [63:0] store_value;
  logic [31:0] fetch_address;
  logic        unknown_instr;

  modport source (output valid, mem_request, access_size, mem_address, store_value,
                  fetch_address, unknown_instr, input ready);
  modport sink (input valid, mem_request, access_size, mem_address, store_value,
                fetch_address, unknown_instr, output ready);
endinterface

// ===== sv/mie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the general register file; depends on nothing.
module mie_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mie_ctrl.sv =====
// Controller state machine of the MIPS64 integer execute core.
// Sequences operand reads, execution and division; owns the result valid flag.
// Depends on mie_pkg.
module mie_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mie_pkg::cmd_t     cmd,
  input  mie_pkg::status_t  st
);

  mie_pkg::state_t state, state_next;
  logic can_fire;

  assign can_fire = !out_valid || out_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mie_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mie_pkg::S_IDLE: if (in_valid) state_next = mie_pkg::S_RS;
      mie_pkg::S_RS:   state_next = mie_pkg::S_RT;
      mie_pkg::S_RT:   state_next = mie_pkg::S_EXEC;
      mie_pkg::S_EXEC: begin
        if (can_fire) state_next = st.div_start ? mie_pkg::S_DIV : mie_pkg::S_IDLE;
      end
      mie_pkg::S_DIV:  if (st.div_done) state_next = mie_pkg::S_IDLE;
      default:         state_next = mie_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      mie_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      mie_pkg::S_RS: begin
        cmd.rd_rt = 1'b1;
        cmd.latch_a = 1'b1;
      end
      mie_pkg::S_RT:   cmd.latch_b = 1'b1;
      mie_pkg::S_EXEC: cmd.exec = can_fire;
      mie_pkg::S_DIV:  cmd.div_step = 1'b1;
      default:         cmd = '0;
    endcase
  end

  // Result valid flag: set by an execution, cleared by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_accept_to_rs: assert property (@(posedge clk) disable iff (rst)
    (state == mie_pkg::S_IDLE && in_valid) |=> state == mie_pkg::S_RS)
    else $error("accepted item did not start an operand read");

  a_div_from_exec: assert property (@(posedge clk) disable iff (rst)
    (state == mie_pkg::S_DIV && $past(state) != mie_pkg::S_DIV)
      |-> $past(state) == mie_pkg::S_EXEC)
    else $error("division entered without an execution");

  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == mie_pkg::S_EXEC)
    else $error("result appeared without an execution");

endmodule

// ===== sv/mie_dp.sv =====
// Datapath of the MIPS64 integer execute core: register file, hi/lo, fetch
// pointer, decode and execute logic, iterative divider and result register.
// Depends on mie_pkg and mie_ram.
module mie_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data,
  input  logic              item_kind,
  input  logic [31:0]       instruction,
  input  logic [63:0]       load_value,
  input  mie_pkg::cmd_t     cmd,
  output mie_pkg::status_t  st,
  output logic [1:0]        mem_request,
  output logic [1:0]        access_size,
  output logic [31:0]       mem_address,
  output logic [63:0]       store_value,
  output logic [31:0]       fetch_address,
  output logic              unknown_instr
);

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00, OP_REGIMM = 6'h01, OP_J = 6'h02, OP_JAL = 6'h03;
  localparam logic [5:0] OP_BEQ = 6'h04, OP_BNE = 6'h05, OP_BLEZ = 6'h06, OP_BGTZ = 6'h07;
  localparam logic [5:0] OP_ADDI = 6'h08, OP_ADDIU = 6'h09, OP_SLTI = 6'h0A;
  localparam logic [5:0] OP_SLTIU = 6'h0B, OP_ANDI = 6'h0C, OP_ORI = 6'h0D;
  localparam logic [5:0] OP_XORI = 6'h0E, OP_LUI = 6'h0F;
  localparam logic [5:0] OP_BEQL = 6'h14, OP_BNEL = 6'h15, OP_BLEZL = 6'h16, OP_BGTZL = 6'h17;
  localparam logic [5:0] OP_DADDI = 6'h18, OP_DADDIU = 6'h19;
  localparam logic [5:0] OP_LB = 6'h20, OP_LH = 6'h21, OP_LW = 6'h23, OP_LBU = 6'h24;
  localparam logic [5:0] OP_LHU = 6'h25, OP_LWU = 6'h27, OP_LD = 6'h37;
  localparam logic [5:0] OP_SB = 6'h28, OP_SH = 6'h29, OP_SW = 6'h2B, OP_SD = 6'h3F;
  // Function codes of the special group.
  localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03, FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08, FN_JALR = 6'h09;
  localparam logic [5:0] FN_MFHI = 6'h10, FN_MFLO = 6'h12, FN_DSLLV = 6'h14;
  localparam logic [5:0] FN_DSRLV = 6'h16, FN_DSRAV = 6'h17, FN_MULT = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19, FN_DIV = 6'h1A, FN_DIVU = 6'h1B;
  localparam logic [5:0] FN_ADD = 6'h20, FN_ADDU = 6'h21, FN_SUB = 6'h22, FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND = 6'h24, FN_OR = 6'h25, FN_XOR = 6'h26, FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2A, FN_SLTU = 6'h2B, FN_DADD = 6'h2C, FN_DADDU = 6'h2D;
  localparam logic [5:0] FN_DSUB = 6'h2E, FN_DSUBU = 6'h2F, FN_DSLL = 6'h38;
  localparam logic [5:0] FN_DSRL = 6'h3A, FN_DSRA = 6'h3B, FN_DSLL32 = 6'h3C;
  localparam logic [5:0] FN_DSRL32 = 6'h3E, FN_DSRA32 = 6'h3F;
  localparam logic [4:0] LINK_REG = 5'd31;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Latched item and operands.
  logic                      kind_q;
  logic [31:0]               ins_q;
  logic [63:0]               ldv_q;
  logic [63:0]               a_q, b_q;

  // Architectural state.
  logic [31:0]               rst_vec, fp, reported;
  logic                      started, annul, load_wait, pend_sgn;
  logic [4:0]                pend_dest;
  logic [1:0]                pend_size;
  logic [63:0]               hi, lo;
  logic [mie_pkg::REG_COUNT-1:0] rf_valid;

  // Register file read side.
  logic [mie_pkg::REG_AW-1:0] raddr, raddr_q;
  logic [63:0]               rf_q, rf_val;

  assign raddr = cmd.rd_rt ? ins_q[20:16] : instruction[25:21];
  assign rf_val = rf_valid[raddr_q] ? rf_q : 64'd0;

  // Decoded fields.
  logic [5:0]  op, fn;
  logic [4:0]  rs_f, rt_f, rd_f, sa;
  logic [15:0] imm;
  logic [63:0] simm, zimm, link;
  logic [31:0] fp_inc, btarget;
  logic        lez, exe, ld_item;

  assign op = ins_q[31:26];
  assign fn = ins_q[5:0];
  assign rs_f = ins_q[25:21];
  assign rt_f = ins_q[20:16];
  assign rd_f = ins_q[15:11];
  assign sa = ins_q[10:6];
  assign imm = ins_q[15:0];
  assign simm = {{48{imm[15]}}, imm};
  assign zimm = {48'd0, imm};
  assign fp_inc = fp + 32'd4;
  assign link = {32'd0, fp_inc + 32'd4};
  assign btarget = fp_inc + {simm[29:0], 2'b00} - 32'd4;
  assign lez = (a_q == 64'd0) || a_q[63];
  assign exe = !kind_q && !annul;
  assign ld_item = kind_q && load_wait;

  // Execute results.
  logic        wb_en, br, br_cond, br_likely, br_link, unk, ld_go, ld_sgn;
  logic        mul_go, mul_sgn, div_go, div_sgn;
  logic [4:0]  wb_idx;
  logic [63:0] wb_val, sval, ld_ext, mem_sum;
  logic [31:0] fp_new;
  logic [1:0]  req, acc;
  logic [5:0]  sh_v64;
  logic [4:0]  sh_v32;
  logic signed [65:0] prod;

  assign sh_v64 = a_q[5:0];
  assign sh_v32 = a_q[4:0];
  assign mem_sum = a_q + simm;
  assign prod = $signed({mul_sgn & a_q[31], a_q[31:0]}) * $signed({mul_sgn & b_q[31], b_q[31:0]});

  // Load data extension by the pending access size.
  always_comb begin
    unique case (pend_size)
      mie_pkg::SIZE_BYTE:   ld_ext = {{56{pend_sgn & ldv_q[7]}}, ldv_q[7:0]};
      mie_pkg::SIZE_HALF:   ld_ext = {{48{pend_sgn & ldv_q[15]}}, ldv_q[15:0]};
      mie_pkg::SIZE_WORD:   ld_ext = {{32{pend_sgn & ldv_q[31]}}, ldv_q[31:0]};
      default:              ld_ext = ldv_q;
    endcase
  end

  // Instruction decode and execute.
  always_comb begin
    wb_en = 1'b0; wb_idx = rd_f; wb_val = 64'd0;
    br = 1'b0; br_cond = 1'b0; br_likely = 1'b0; br_link = 1'b0;
    unk = 1'b0; ld_go = 1'b0; ld_sgn = 1'b0;
    mul_go = 1'b0; mul_sgn = 1'b0; div_go = 1'b0; div_sgn = 1'b0;
    req = mie_pkg::REQ_NONE; acc = mie_pkg::SIZE_BYTE; sval = 64'd0;
    fp_new = fp_inc;
    unique case (op)
      OP_SPECIAL: begin
        wb_en = 1'b1;
        unique case (fn)
          FN_SLL:   wb_val = sx32(b_q[31:0] << sa);
          FN_SRL:   wb_val = sx32(b_q[31:0] >> sa);
          FN_SRA:   wb_val = sx32($unsigned($signed(b_q[31:0]) >>> sa));
          FN_SLLV:  wb_val = sx32(b_q[31:0] << sh_v32);
          FN_SRLV:  wb_val = sx32(b_q[31:0] >> sh_v32);
          FN_SRAV:  wb_val = sx32($unsigned($signed(b_q[31:0]) >>> sh_v32));
          FN_JR: begin
            wb_en = 1'b0;
            fp_new = a_q[31:0] - 32'd4;
          end
          FN_JALR: begin
            wb_val = link;
            fp_new = a_q[31:0] - 32'd4;
          end
          FN_MFHI:  wb_val = hi;
          FN_MFLO:  wb_val = lo;
          FN_DSLLV: wb_val = b_q << sh_v64;
          FN_DSRLV: wb_val = b_q >> sh_v64;
          FN_DSRAV: wb_val = $unsigned($signed(b_q) >>> sh_v64);
          FN_MULT, FN_MULTU: begin
            wb_en = 1'b0;
            mul_go = 1'b1;
            mul_sgn = (fn == FN_MULT);
          end
          FN_DIV, FN_DIVU: begin
            wb_en = 1'b0;
            div_go = (b_q[31:0] != 32'd0);
            div_sgn = (fn == FN_DIV);
          end
          FN_ADD, FN_ADDU:   wb_val = sx32(a_q[31:0] + b_q[31:0]);
          FN_SUB, FN_SUBU:   wb_val = sx32(a_q[31:0] - b_q[31:0]);
          FN_AND:   wb_val = a_q & b_q;
          FN_OR:    wb_val = a_q | b_q;
          FN_XOR:   wb_val = a_q ^ b_q;
          FN_NOR:   wb_val = ~(a_q | b_q);
          FN_SLT:   wb_val = {63'd0, $signed(a_q) < $signed(b_q)};
          FN_SLTU:  wb_val = {63'd0, a_q < b_q};
          FN_DADD, FN_DADDU: wb_val = a_q + b_q;
          FN_DSUB, FN_DSUBU: wb_val = a_q - b_q;
          FN_DSLL:  wb_val = b_q << sa;
          FN_DSRL:  wb_val = b_q >> sa;
          FN_DSRA:  wb_val = $unsigned($signed(b_q) >>> sa);
          FN_DSLL32: wb_val = b_q << ({1'b0, sa} + 6'd32);
          FN_DSRL32: wb_val = b_q >> ({1'b0, sa} + 6'd32);
          FN_DSRA32: wb_val = $unsigned($signed(b_q) >>> ({1'b0, sa} + 6'd32));
          default: begin
            wb_en = 1'b0;
            unk = 1'b1;
          end
        endcase
      end
      OP_REGIMM: begin
        // Bit 0 selects the not-negative test, bit 1 likely, bit 4 link.
        if (rt_f[3:2] == 2'b00 && rt_f[4:0] != 5'd4 && (rt_f[4] == 1'b0 || rt_f[3] == 1'b0)) begin
          br = 1'b1;
          br_cond = rt_f[0] ? !a_q[63] : a_q[63];
          br_likely = rt_f[1];
          br_link = rt_f[4];
        end else begin
          unk = 1'b1;
        end
      end
      OP_J, OP_JAL: begin
        wb_en = (op == OP_JAL);
        wb_idx = LINK_REG;
        wb_val = link;
        fp_new = {fp_inc[31:28], ins_q[25:0], 2'b00} - 32'd4;
      end
      OP_BEQ, OP_BEQL: begin
        br = 1'b1; br_cond = (a_q == b_q); br_likely = (op == OP_BEQL);
      end
      OP_BNE, OP_BNEL: begin
        br = 1'b1; br_cond = (a_q != b_q); br_likely = (op == OP_BNEL);
      end
      OP_BLEZ, OP_BLEZL: begin
        br = 1'b1; br_cond = lez; br_likely = (op == OP_BLEZL);
      end
      OP_BGTZ, OP_BGTZL: begin
        br = 1'b1; br_cond = !lez; br_likely = (op == OP_BGTZL);
      end
      OP_ADDI, OP_ADDIU: begin
        wb_en = 1'b1; wb_idx = rt_f; wb_val = sx32(a_q[31:0] + simm[31:0]);
      end
      OP_SLTI: begin
        wb_en = 1'b1; wb_idx = rt_f; wb_val = {63'd0, $signed(a_q) < $signed(simm)};
      end
      OP_SLTIU: begin
        wb_en = 1'b1; wb_idx = rt_f; wb_val = {63'd0, a_q < simm};
      end
      OP_ANDI: begin
        wb_en = 1'b1; wb_idx = rt_f; wb_val = a_q & zimm;
      end
      OP_ORI: begin
        wb_en = 1'b1; wb_idx = rt_f; wb_val = a_q | zimm;
      end
      OP_XORI: begin
        wb_en = 1'b1; wb_idx = rt_f; wb_val = a_q ^ zimm;
      end
      OP_LUI: begin
        wb_en = 1'b1; wb_idx = rt_f; wb_val = sx32({imm, 16'd0});
      end
      OP_DADDI, OP_DADDIU: begin
        wb_en = 1'b1; wb_idx = rt_f; wb_val = a_q + simm;
      end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_LWU, OP_LD: begin
        ld_go = 1'b1;
        req = mie_pkg::REQ_READ;
        ld_sgn = !op[2] && (op != OP_LD);
        unique case (op)
          OP_LB, OP_LBU: acc = mie_pkg::SIZE_BYTE;
          OP_LH, OP_LHU: acc = mie_pkg::SIZE_HALF;
          OP_LW, OP_LWU: acc = mie_pkg::SIZE_WORD;
          default:       acc = mie_pkg::SIZE_DOUBLE;
        endcase
      end
      OP_SB: begin
        req = mie_pkg::REQ_WRITE; acc = mie_pkg::SIZE_BYTE; sval = {56'd0, b_q[7:0]};
      end
      OP_SH: begin
        req = mie_pkg::REQ_WRITE; acc = mie_pkg::SIZE_HALF; sval = {48'd0, b_q[15:0]};
      end
      OP_SW: begin
        req = mie_pkg::REQ_WRITE; acc = mie_pkg::SIZE_WORD; sval = {32'd0, b_q[31:0]};
      end
      OP_SD: begin
        req = mie_pkg::REQ_WRITE; acc = mie_pkg::SIZE_DOUBLE; sval = b_q;
      end
      default: unk = 1'b1;
    endcase
    // Linking branches link whether taken or not; branches redirect only when taken.
    if (br) begin
      wb_en = br_link;
      wb_idx = LINK_REG;
      wb_val = link;
      if (br_cond) fp_new = btarget;
    end
  end

  // Register file write.
  logic        rf_we;
  logic [4:0]  rf_widx;
  logic [63:0] rf_wdata;

  always_comb begin
    rf_we = 1'b0;
    rf_widx = wb_idx;
    rf_wdata = wb_val;
    if (cmd.exec && exe && wb_en) begin
      rf_we = (wb_idx != 5'd0);
    end else if (cmd.exec && ld_item) begin
      rf_we = (pend_dest != 5'd0);
      rf_widx = pend_dest;
      rf_wdata = ld_ext;
    end
  end

  mie_ram #(.WIDTH(64), .DEPTH(mie_pkg::REG_COUNT)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_widx),
    .wdata (rf_wdata),
    .raddr (raddr),
    .rdata (rf_q)
  );

  // Iterative restoring divider on 32-bit magnitudes.
  logic [31:0] dv_rem, dv_q, dv_mb;
  logic        dv_qneg, dv_rneg;
  logic [4:0]  dv_cnt;
  logic [32:0] dv_trial;
  logic [31:0] dv_rem_next, dv_q_next, dv_qf, dv_rf;

  assign dv_trial = {dv_rem, dv_q[31]} - {1'b0, dv_mb};
  assign dv_rem_next = dv_trial[32] ? {dv_rem[30:0], dv_q[31]} : dv_trial[31:0];
  assign dv_q_next = {dv_q[30:0], !dv_trial[32]};
  assign dv_qf = dv_qneg ? 32'd0 - dv_q_next : dv_q_next;
  assign dv_rf = dv_rneg ? 32'd0 - dv_rem_next : dv_rem_next;

  assign st.div_start = exe && div_go;
  assign st.div_done = (dv_cnt == 5'd31);

  always_ff @(posedge clk) begin
    if (cmd.exec && exe && div_go) begin
      dv_rem <= 32'd0;
      dv_q <= (div_sgn && a_q[31]) ? 32'd0 - a_q[31:0] : a_q[31:0];
      dv_mb <= (div_sgn && b_q[31]) ? 32'd0 - b_q[31:0] : b_q[31:0];
      dv_qneg <= div_sgn && (a_q[31] ^ b_q[31]);
      dv_rneg <= div_sgn && a_q[31];
      dv_cnt <= 5'd0;
    end else if (cmd.div_step) begin
      dv_rem <= dv_rem_next;
      dv_q <= dv_q_next;
      dv_cnt <= dv_cnt + 5'd1;
    end
  end

  // Item and operand latches.
  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    if (cmd.accept) begin
      kind_q <= item_kind;
      ins_q <= instruction;
      ldv_q <= load_value;
    end
    if (cmd.latch_a) a_q <= rf_val;
    if (cmd.latch_b) b_q <= rf_val;
  end

  // Architectural state and valid bits of the register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      rst_vec <= mie_pkg::RESET_VECTOR_DEFAULT;
      fp <= mie_pkg::RESET_VECTOR_DEFAULT;
      reported <= mie_pkg::RESET_VECTOR_DEFAULT;
      started <= 1'b0;
      annul <= 1'b0;
      load_wait <= 1'b0;
      pend_dest <= 5'd0;
      pend_size <= 2'd0;
      pend_sgn <= 1'b0;
      hi <= 64'd0;
      lo <= 64'd0;
      rf_valid <= '0;
    end else begin
      if (rf_we) rf_valid[rf_widx] <= 1'b1;
      if (cfg_we) begin
        rst_vec <= cfg_data;
        if (!started) begin
          fp <= cfg_data;
          reported <= cfg_data;
        end
      end
      if (cmd.exec && !kind_q) begin
        started <= 1'b1;
        reported <= fp_inc;
        if (annul) begin
          annul <= 1'b0;
          fp <= fp_inc;
        end else begin
          fp <= fp_new;
          annul <= br && !br_cond && br_likely;
          if (ld_go) begin
            load_wait <= 1'b1;
            pend_dest <= rt_f;
            pend_size <= acc;
            pend_sgn <= ld_sgn;
          end
          if (mul_go) begin
            hi <= sx32(prod[63:32]);
            lo <= sx32(prod[31:0]);
          end
        end
      end else if (cmd.exec && ld_item) begin
        load_wait <= 1'b0;
      end
      if (cmd.div_step && st.div_done) begin
        lo <= sx32(dv_qf);
        hi <= sx32(dv_rf);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      mem_request <= mie_pkg::REQ_NONE;
      access_size <= mie_pkg::SIZE_BYTE;
      mem_address <= 32'd0;
      store_value <= 64'd0;
      unknown_instr <= 1'b0;
      fetch_address <= kind_q ? reported : fp_inc;
      if (exe) begin
        mem_request <= req;
        unknown_instr <= unk;
        if (req != mie_pkg::REQ_NONE) begin
          access_size <= acc;
          mem_address <= mem_sum[31:0];
          store_value <= sval;
        end
      end
    end
  end

endmodule

// ===== sv/mips64_integer_execute_core.sv =====
// Top level of the MIPS64 integer execute core.
// Joins the controller and the datapath; depends on mie_pkg, both channel
// interfaces, mie_ctrl and mie_dp.
//
// The items channel takes instruction words (item_kind 0) fetched at the last
// reported fetch address, and load data (item_kind 1) for a pending load.
// Each accepted item gives exactly one result on the results channel: the
// memory request, if any, the next fetch address and the unknown flag.
// The user writes the reset_vector register via cfg_we/cfg_data only while the
// block is idle, not enforced by the block; it also sets the first fetch address.
// An item passes from transfer to result through two register file reads
// over the single read port, then an execute step that loads the result
// register. Divides then run the iterative divider to completion before
// the next item is taken; multiplies finish in the execute step.
// The next item is accepted while a result waits in the output register; if
// the receiver stalls, the following item holds in its execute step.
// Synchronous reset clears control state and hi/lo, and sets the fetch
// pointer to 0xBFC00000; register file entries clear at once via valid bits.
module mips64_integer_execute_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_data,
  mie_item_if.sink     items,
  mie_result_if.source results
);

  mie_pkg::cmd_t    cmd;
  mie_pkg::status_t st;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .st        (st)
  );

  mie_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .item_kind     (items.item_kind),
    .instruction   (items.instruction),
    .load_value    (items.load_value),
    .cmd           (cmd),
    .st            (st),
    .mem_request   (results.mem_request),
    .access_size   (results.access_size),
    .mem_address   (results.mem_address),
    .store_value   (results.store_value),
    .fetch_address (results.fetch_address),
    .unknown_instr (results.unknown_instr)
  );

endmodule
